// ===== design/spp_pkg.sv =====
// Package with shared types, constants and functions of the step pattern player.
`timescale 1ns / 1ps
`default_nettype none
package spp_pkg;

  localparam int TRACKS_DEF = 16;
  localparam int STEPS_DEF  = 32;

  localparam logic [2:0] NO_PAT  = 3'd7;
  localparam logic [9:0] BAR_MAX = 10'd999;

  localparam logic [1:0] MODE_PLAY    = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_WRITE   = 2'd2;
  localparam logic [1:0] MODE_STOP    = 2'd3;

  localparam logic [1:0] KIND_OFF   = 2'd0;
  localparam logic [1:0] KIND_NOTE  = 2'd1;
  localparam logic [1:0] KIND_TEMPO = 2'd2;
  localparam logic [1:0] KIND_POS   = 2'd3;

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_BEAT = 2'd1;
  localparam logic [1:0] MARK_BAR  = 2'd2;

  localparam logic [2:0] REG_STEP_COUNT = 3'd0;
  localparam logic [2:0] REG_TRACK_COUNT = 3'd1;
  localparam logic [2:0] REG_SPB = 3'd2;
  localparam logic [2:0] REG_BPB = 3'd3;
  localparam logic [2:0] REG_MUTE = 3'd4;
  localparam logic [2:0] REG_SOLO = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] pulse_index;
    logic [3:0] track_sel;
    logic [4:0] step_sel;
    logic [6:0] new_velocity;
    logic [2:0] sub_pattern;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] note_track;
    logic [6:0] note_velocity;
    logic [1:0] tempo_mark;
    logic [4:0] pos_step;
    logic [4:0] pos_sub;
    logic [4:0] pos_beat;
    logic [9:0] pos_bar;
    logic       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted item
    logic wr_mem;    // perform a step write
    logic clr_mem;   // clearing pass write at the sweep address
    logic rd_mem;    // read the entry of the scanned track
    logic trk_first; // start the track scan at zero
    logic trk_next;  // move to the next track
    logic pos_adv;   // start the position advance
    logic pos_step;  // one step of the position divider
    logic pos_stop;  // return the position to its start
    logic emit;      // present a result
    logic [1:0] emit_kind;
  } spp_cmd_t;

  typedef struct packed {
    logic       trk_done;  // scanned track index reached the used count
    logic       note_hit;  // the read entry fires a note
    logic       div_done;  // position divider finished
    logic       clr_done;  // clearing sweep at its last entry
    logic       out_busy;  // output register is full and stalled
    logic [1:0] mode;
    logic       pulse_zero;
  } spp_sts_t;

  // Sub-step pulse mask table; bit p fires at pulse p.
  function automatic logic [5:0] pulse_mask(input logic [2:0] idx);
    logic [5:0] m;
    m = 6'b000000;
    unique case (idx)
      3'd0: m = 6'b000001;
      3'd1: m = 6'b000100;
      3'd2: m = 6'b010000;
      3'd3: m = 6'b010001;
      3'd4: m = 6'b000100;
      3'd5: m = 6'b001001;
      3'd6: m = 6'b010101;
      default: m = 6'b000000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== design/spp_ctrl.sv =====
// Controller state machine of the step pattern player.
`timescale 1ns / 1ps
`default_nettype none
module spp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire spp_pkg::spp_sts_t sts,
  output spp_pkg::spp_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_OFF, S_READ, S_WAIT, S_CHECK, S_TEMPO,
    S_DIV, S_POS
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_mem = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.mode)
          spp_pkg::MODE_PLAY: begin
            cmd.trk_first = 1'b1;
            state_nxt = sts.pulse_zero ? S_OFF : S_READ;
          end
          spp_pkg::MODE_ADVANCE: begin
            cmd.pos_adv = 1'b1;
            state_nxt = S_DIV;
          end
          spp_pkg::MODE_WRITE: begin
            cmd.wr_mem = 1'b1;
            state_nxt = S_IDLE;
          end
          default: begin
            cmd.pos_stop = 1'b1;
            state_nxt = S_POS;
          end
        endcase
      end
      S_OFF: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = spp_pkg::KIND_OFF;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (sts.trk_done) begin
          state_nxt = S_TEMPO;
        end else begin
          cmd.rd_mem = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_CHECK;
      S_CHECK: begin
        if (!sts.note_hit) begin
          cmd.trk_next = 1'b1;
          state_nxt = S_READ;
        end else if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = spp_pkg::KIND_NOTE;
          cmd.trk_next = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_TEMPO: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = spp_pkg::KIND_TEMPO;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.pos_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = spp_pkg::KIND_POS;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/spp_datapath.sv =====
// Datapath of the step pattern player: pattern memory, position and output register.
`timescale 1ns / 1ps
`default_nettype none
module spp_datapath #(
  parameter int TRACKS = spp_pkg::TRACKS_DEF,
  parameter int STEPS  = spp_pkg::STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spp_pkg::in_item_t  in_data,
  input  wire spp_pkg::spp_cmd_t  cmd,
  output spp_pkg::spp_sts_t       sts,
  input  wire logic               cfg_valid,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output spp_pkg::out_item_t      out_data
);

  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int SW = $clog2(STEPS);
  localparam int AW = TW + SW;
  localparam int DEPTH = TRACKS * STEPS;
  localparam int TCW = $clog2(TRACKS + 1);

  // Configuration registers.
  logic [5:0]  step_count_r;
  logic [4:0]  track_count_r, spb_r, bpb_r, solo_r;
  logic [15:0] mute_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r  <= 6'd16;
      track_count_r <= 5'd16;
      spb_r         <= 5'd4;
      bpb_r         <= 5'd4;
      mute_r        <= 16'd0;
      solo_r        <= 5'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spp_pkg::REG_STEP_COUNT:  step_count_r  <= cfg_data[5:0];
        spp_pkg::REG_TRACK_COUNT: track_count_r <= cfg_data[4:0];
        spp_pkg::REG_SPB:         spb_r         <= cfg_data[4:0];
        spp_pkg::REG_BPB:         bpb_r         <= cfg_data[4:0];
        spp_pkg::REG_MUTE:        mute_r        <= cfg_data;
        spp_pkg::REG_SOLO:        solo_r        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Used counts, clamped to the memory geometry.
  logic [6:0] used_steps;
  logic [6:0] used_tracks;
  assign used_steps  = ({1'b0, step_count_r} < 7'(STEPS)) ? {1'b0, step_count_r} : 7'(STEPS);
  assign used_tracks = ({2'b0, track_count_r} < 7'(TRACKS)) ? {2'b0, track_count_r}
                                                              : 7'(TRACKS);

  spp_pkg::in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // Pattern memory: velocity and sub-pattern index in one word.
  logic [9:0]    mem [DEPTH];
  logic [9:0]    rd_q_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] wr_addr;
  logic [9:0]    wr_word;
  logic          wr_en;
  logic          wr_ok;
  logic [TCW-1:0] trk_r;
  logic [4:0]    cur_step_r;

  assign wr_ok = ({3'b0, item_r.track_sel} < used_tracks) &&
                 ({2'b0, item_r.step_sel} < used_steps);

  always_comb begin
    wr_addr = clr_addr_r;
    wr_word = {7'd0, spp_pkg::NO_PAT};
    wr_en   = cmd.clr_mem;
    if (cmd.wr_mem) begin
      wr_addr = AW'(AW'(item_r.track_sel) * AW'(STEPS) + AW'(item_r.step_sel));
      wr_word = (item_r.new_velocity == 7'd0) ? {7'd0, spp_pkg::NO_PAT}
                                             : {item_r.new_velocity, item_r.sub_pattern};
      wr_en   = wr_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (cmd.rd_mem) begin
      rd_q_r <= mem[AW'(AW'(trk_r[TW-1:0]) * AW'(STEPS) + AW'(cur_step_r))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_mem) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end
  assign sts.clr_done = (clr_addr_r == AW'(DEPTH - 1));

  // Track scan.
  always_ff @(posedge clk) begin
    if (cmd.trk_first) begin
      trk_r <= '0;
    end else if (cmd.trk_next) begin
      trk_r <= trk_r + TCW'(1);
    end
  end
  assign sts.trk_done = (7'(trk_r) >= used_tracks);

  logic muted, solo_ok, pat_ok;
  logic [7:0] mask;
  assign muted   = (7'(trk_r) < 7'd16) && mute_r[trk_r[TW-1:0] & 4'(15)];
  assign solo_ok = (solo_r == 5'd16) || (7'(solo_r) == 7'(trk_r));
  // Pulses 6 and 7 land on the two zero bits on top of the mask.
  assign mask    = {2'b00, spp_pkg::pulse_mask(rd_q_r[2:0])};
  assign pat_ok  = (rd_q_r[2:0] != spp_pkg::NO_PAT) && mask[item_r.pulse_index];
  assign sts.note_hit = !muted && solo_ok && (cur_step_r < 5'(STEPS) || STEPS > 31) &&
                        pat_ok && (rd_q_r[9:3] != 7'd0);

  // Position counters; sub and beat come from a step-at-a-time divider.
  logic [4:0] sub_r, beat_r;
  logic [9:0] bar_r;
  logic [4:0] rem_r, beat_cnt_r;
  logic [4:0] spb, bpb;
  logic [4:0] step_new;
  assign spb = (spb_r == 5'd0) ? 5'd1 : spb_r;
  assign bpb = (bpb_r == 5'd0) ? 5'd1 : bpb_r;
  assign step_new = ({2'b0, cur_step_r} + 7'd2 > used_steps) ? 5'd0 : cur_step_r + 5'd1;

  // Divider: counts rem from 0 to step, wrapping at spb, and beats at bpb.
  logic [4:0] div_cnt_r;
  logic       div_fin;
  assign div_fin = (div_cnt_r == cur_step_r);
  assign sts.div_done = div_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_step_r <= '0;
      sub_r <= 5'd1;
      beat_r <= 5'd1;
      bar_r <= 10'd1;
    end else if (cmd.pos_stop) begin
      cur_step_r <= '0;
      sub_r <= 5'd1;
      beat_r <= 5'd1;
      bar_r <= 10'd1;
    end else if (cmd.pos_adv) begin
      cur_step_r <= step_new;
      div_cnt_r <= '0;
      rem_r <= '0;
      beat_cnt_r <= '0;
    end else if (cmd.pos_step) begin
      if (div_fin) begin
        sub_r <= rem_r + 5'd1;
        beat_r <= beat_cnt_r + 5'd1;
        if (rem_r == 5'd0 && beat_cnt_r == 5'd0) begin
          bar_r <= (bar_r < spp_pkg::BAR_MAX) ? bar_r + 10'd1 : 10'd1;
        end
      end else begin
        div_cnt_r <= div_cnt_r + 5'd1;
        if (rem_r + 5'd1 >= spb) begin
          rem_r <= '0;
          beat_cnt_r <= (beat_cnt_r + 5'd1 >= bpb) ? 5'd0 : beat_cnt_r + 5'd1;
        end else begin
          rem_r <= rem_r + 5'd1;
        end
      end
    end
  end

  // Output register.
  spp_pkg::out_item_t res;
  always_comb begin
    res = '0;
    res.kind = cmd.emit_kind;
    res.last = 1'b0;
    unique case (cmd.emit_kind)
      spp_pkg::KIND_NOTE: begin
        res.note_track = trk_r[3:0] & {4{1'b1}};
        res.note_velocity = rd_q_r[9:3];
      end
      spp_pkg::KIND_TEMPO: begin
        res.tempo_mark = (sub_r == 5'd1) ? ((beat_r == 5'd1) ? spp_pkg::MARK_BAR
                                                              : spp_pkg::MARK_BEAT)
                                         : spp_pkg::MARK_NONE;
        res.last = 1'b1;
      end
      spp_pkg::KIND_POS: begin
        res.pos_step = cur_step_r;
        res.pos_sub = sub_r;
        res.pos_beat = beat_r;
        res.pos_bar = bar_r;
        res.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= res;
    end
  end

  assign sts.out_busy   = out_valid && out_stall;
  assign sts.mode       = item_r.mode;
  assign sts.pulse_zero = (item_r.pulse_index == 3'd0);

endmodule
`default_nettype wire

// ===== design/step_pattern_player.sv =====
// A play pulse visits the used tracks one by one through the one read port of the
// pattern memory. One item is in work at a time; a result waits in the output register.
// After reset a clearing pass over all TRACKS*STEPS entries (512 by default) runs
// before the first item is taken; configuration writes are accepted throughout.
`timescale 1ns / 1ps
`default_nettype none
module step_pattern_player #(
  parameter int TRACKS = spp_pkg::TRACKS_DEF,
  parameter int STEPS  = spp_pkg::STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire spp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output spp_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  spp_pkg::spp_cmd_t cmd;
  spp_pkg::spp_sts_t sts;

  assign cfg_ready = 1'b1;

  spp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spp_datapath #(
    .TRACKS (TRACKS),
    .STEPS  (STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
